>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module of the project
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is applied
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/dtt_pkg.sv
// ----------------------------------------------------------------------------
// dtt_pkg
// Types, sizes and codes shared by the task table modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtt_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int WORD_WIDTH  = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int OPT_W       = 5;

  // operation codes
  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  // bit positions in the add options
  localparam int OPT_APPEND  = 0;
  localparam int OPT_REFUSE  = 1;
  localparam int OPT_REPLACE = 2;
  localparam int OPT_FIRST   = 3;
  localparam int OPT_SECOND  = 4;

  // result status codes
  typedef enum logic [2:0] {
    ST_APPENDED = 3'd0,
    ST_REPLACED = 3'd1,
    ST_REFUSED  = 3'd2,
    ST_KEPT     = 3'd3,
    ST_FULL     = 3'd4,
    ST_DELETED  = 3'd5
  } status_e;

  // one stored task
  typedef struct packed {
    logic [WORD_WIDTH-1:0] handler;
    logic [WORD_WIDTH-1:0] first;
    logic [WORD_WIDTH-1:0] second;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // which argument words take part in a compare
  typedef struct packed {
    logic use_first;
    logic use_second;
  } match_sel_t;

endpackage

>>> design/dedup_task_table.sv
// ----------------------------------------------------------------------------
// dedup_task_table
// Ordered task table with duplicate-aware add and compacting delete
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the result is out. The result is shown for exactly one cycle with
// done_o high and cannot be held off, so the receiver must take it then.
// The table sits in one memory with a read port and a write port, read one
// entry per cycle and checked by one compare unit: an add or delete reads
// the stored entries in order, an add that matches an entry stops there,
// and an append-always add or any item on an empty table skips the scan.
// A new item may be accepted in the cycle that done_o is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dedup_task_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                mode_i,
  input  logic [dtt_pkg::OPT_W-1:0]           add_options_i,
  input  logic [dtt_pkg::WORD_WIDTH-1:0]      func_handle_i,
  input  logic [dtt_pkg::WORD_WIDTH-1:0]      arg_first_i,
  input  logic [dtt_pkg::WORD_WIDTH-1:0]      arg_second_i,
  output logic                                done_o,
  output dtt_pkg::status_e                    status_o,
  output logic [dtt_pkg::IDX_W-1:0]           slot_o,
  output logic [dtt_pkg::CNT_W-1:0]           entry_total_o
);

  import dtt_pkg::*;

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] keep_q, keep_d;
  logic             chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0] chk_idx_q, chk_idx_d;
  logic             found_q, found_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic             done_q, done_d;

  logic             mode_q, mode_d;
  logic [OPT_W-1:0] opts_q, opts_d;
  entry_t           item_q, item_d;

  status_e          status_q, status_d;
  logic [IDX_W-1:0] slot_out_q, slot_out_d;
  logic [CNT_W-1:0] total_q, total_d;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic             ram_re;
  entry_t           ram_rdata;
  logic             issue;
  logic             last_chk;
  logic             hit;
  match_sel_t       sel;

  // task table memory
  dtt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_dtt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // delete compares on the handler alone
  assign sel.use_first  = (mode_q == MODE_ADD) && opts_q[OPT_FIRST];
  assign sel.use_second = (mode_q == MODE_ADD) && opts_q[OPT_SECOND];

  dtt_match u_dtt_match (
    .entry_i (ram_rdata),
    .item_i  (item_q),
    .sel_i   (sel),
    .match_o (hit)
  );

  // scan bookkeeping
  assign issue    = rd_ptr_q != fill_q;
  assign last_chk = {1'b0, chk_idx_q} == (fill_q - CNT_W'(1));

  // sequencer
  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    rd_ptr_d   = rd_ptr_q;
    keep_d     = keep_q;
    chk_vld_d  = 1'b0;
    chk_idx_d  = chk_idx_q;
    found_d    = found_q;
    slot_d     = slot_q;
    done_d     = 1'b0;
    mode_d     = mode_q;
    opts_d     = opts_q;
    item_d     = item_q;
    status_d   = status_q;
    slot_out_d = slot_out_q;
    total_d    = total_q;
    ram_we     = 1'b0;
    ram_waddr  = slot_q;
    ram_wdata  = item_q;
    ram_re     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          mode_d         = mode_i;
          opts_d         = add_options_i;
          item_d.handler = func_handle_i;
          item_d.first   = arg_first_i;
          item_d.second  = arg_second_i;
          rd_ptr_d       = '0;
          keep_d         = '0;
          found_d        = 1'b0;
          slot_d         = '0;
          if (((mode_i == MODE_ADD) && add_options_i[OPT_APPEND]) || (fill_q == '0)) begin
            state_d = S_FINISH;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // read ahead one entry while the previous one is compared
        if (issue) begin
          ram_re    = 1'b1;
          rd_ptr_d  = rd_ptr_q + CNT_W'(1);
          chk_vld_d = 1'b1;
          chk_idx_d = rd_ptr_q[IDX_W-1:0];
        end
        if (chk_vld_q) begin
          if (mode_q == MODE_ADD) begin
            if (hit) begin
              found_d = 1'b1;
              slot_d  = chk_idx_q;
              state_d = S_FINISH;
            end else if (last_chk) begin
              state_d = S_FINISH;
            end
          end else begin
            // survivors move down to the next kept position
            if (!hit) begin
              ram_we    = 1'b1;
              ram_waddr = keep_q[IDX_W-1:0];
              ram_wdata = ram_rdata;
              keep_d    = keep_q + CNT_W'(1);
            end
            if (last_chk) begin
              state_d = S_FINISH;
            end
          end
        end
      end

      S_FINISH: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        priority if (mode_q == MODE_DELETE) begin
          fill_d     = keep_q;
          status_d   = ST_DELETED;
          slot_out_d = '0;
          total_d    = keep_q;
        end else if (found_q) begin
          slot_out_d = slot_q;
          total_d    = fill_q;
          priority if (opts_q[OPT_REPLACE]) begin
            ram_we   = 1'b1;
            status_d = ST_REPLACED;
          end else if (opts_q[OPT_REFUSE]) begin
            status_d = ST_REFUSED;
          end else begin
            status_d = ST_KEPT;
          end
        end else if (fill_q == CNT_W'(TABLE_DEPTH)) begin
          status_d   = ST_FULL;
          slot_out_d = '0;
          total_d    = fill_q;
        end else begin
          ram_we     = 1'b1;
          ram_waddr  = fill_q[IDX_W-1:0];
          status_d   = ST_APPENDED;
          slot_out_d = fill_q[IDX_W-1:0];
          fill_d     = fill_q + CNT_W'(1);
          total_d    = fill_q + CNT_W'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fill_q    <= '0;
      rd_ptr_q  <= '0;
      keep_q    <= '0;
      chk_vld_q <= 1'b0;
      chk_idx_q <= '0;
      found_q   <= 1'b0;
      slot_q    <= '0;
      done_q    <= 1'b0;
      mode_q    <= MODE_ADD;
      opts_q    <= '0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      rd_ptr_q  <= rd_ptr_d;
      keep_q    <= keep_d;
      chk_vld_q <= chk_vld_d;
      chk_idx_q <= chk_idx_d;
      found_q   <= found_d;
      slot_q    <= slot_d;
      done_q    <= done_d;
      mode_q    <= mode_d;
      opts_q    <= opts_d;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    status_q   <= status_d;
    slot_out_q <= slot_out_d;
    total_q    <= total_d;
  end

  assign busy          = state_q != S_IDLE;
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign slot_o        = slot_out_q;
  assign entry_total_o = total_q;

endmodule

>>> design/dtt_ram.sv
// ----------------------------------------------------------------------------
// dtt_ram
// Generic single write port, single read port RAM with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/dtt_match.sv
// ----------------------------------------------------------------------------
// dtt_match
// Shared compare unit: checks one stored entry against the current item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtt_match (
  input  dtt_pkg::entry_t     entry_i,
  input  dtt_pkg::entry_t     item_i,
  input  dtt_pkg::match_sel_t sel_i,
  output logic                match_o
);

  import dtt_pkg::*;

  logic handler_eq;
  logic first_ok;
  logic second_ok;

  // handler always compared, argument words only when selected
  assign handler_eq = entry_i.handler == item_i.handler;
  assign first_ok   = !sel_i.use_first  || (entry_i.first  == item_i.first);
  assign second_ok  = !sel_i.use_second || (entry_i.second == item_i.second);
  assign match_o    = handler_eq && first_ok && second_ok;

endmodule

>>> design/dtt_checker.sv
// ----------------------------------------------------------------------------
// dtt_checker
// Port-level checks of the task table, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dtt_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input logic                           done_o,
  input dtt_pkg::status_e               status_o,
  input logic [dtt_pkg::IDX_W-1:0]      slot_o,
  input logic [dtt_pkg::CNT_W-1:0]      entry_total_o
);

  import dtt_pkg::*;

  // a transfer in starts the work
  `ASSERT_CLK(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy, "accept did not raise busy")

  // a result only ends a stretch of work
  `ASSERT_CLK(a_done_after_busy, clk_i, rst_ni, done_o |-> $past(busy), "result without work")

  // one result per item
  `ASSERT_CLK(a_done_single, clk_i, rst_ni, done_o |=> !done_o, "result strobe longer than one cycle")

  // full and delete results carry no slot
  `ASSERT_CLK(a_slot_zero, clk_i, rst_ni, (done_o && (status_o == ST_FULL || status_o == ST_DELETED)) |-> (slot_o == '0), "slot not zero")

  // an append lands at the old end of the table
  `ASSERT_CLK(a_append_slot, clk_i, rst_ni, (done_o && status_o == ST_APPENDED) |-> ({1'b0, slot_o} == entry_total_o - CNT_W'(1)), "append slot off the end")

endmodule

bind dedup_task_table dtt_checker u_dtt_checker (.*);
